### rtl/mrm_pkg.sv
package mrm_pkg;

  localparam int DIM           = 4;
  localparam int ROW_W         = 2;
  localparam int ELEM_W        = 32;
  localparam int PROD_W        = 2 * ELEM_W;
  // four floor-shifted Q32.32 terms need two guard bits above the product
  localparam int SUM_W         = PROD_W + 2;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FIELDS_W      = ROW_W + DIM * ELEM_W;
  localparam int TDATA_W       = ((FIELDS_W + 7) / 8) * 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MUL  = 1'b1;

  localparam logic [ELEM_W-1:0] SAT_POS = {1'b0, {(ELEM_W - 1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_NEG = {1'b1, {(ELEM_W - 1){1'b0}}};

  // transaction as it moves along the cell chain
  typedef struct packed {
    logic                           op;
    logic [ROW_W-1:0]               row;
    logic [DIM-1:0][ELEM_W-1:0]     elems;
    logic [DIM-1:0][SUM_W-1:0]      sums;
  } chain_t;

endpackage

### rtl/mrm_cell.sv
module mrm_cell #(
  parameter int CELL_IDX  = 0,
  parameter int FRAC_BITS = mrm_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mrm_pkg::chain_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output mrm_pkg::chain_t out_data
);
  import mrm_pkg::*;

  localparam logic [ROW_W-1:0] MY_ROW = ROW_W'(CELL_IDX);

  // row CELL_IDX of the right-hand matrix
  logic [DIM-1:0][ELEM_W-1:0] brow;

  logic                       v1;
  logic                       v2;
  chain_t                     d1;
  chain_t                     d2;
  chain_t                     d2_next;
  logic signed [PROD_W-1:0]   prod [DIM];
  logic signed [PROD_W-1:0]   mul  [DIM];
  logic                       load1;
  logic                       load2;

  assign load2     = !v2 || out_ready;
  assign load1     = !v1 || load2;
  assign in_ready  = load1;
  assign out_valid = v2;
  assign out_data  = d2;

  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      mul[j] = $signed(in_data.elems[CELL_IDX]) * $signed(brow[j]);
    end
  end

  always_comb begin
    d2_next = d1;
    for (int j = 0; j < DIM; j++) begin
      d2_next.sums[j] = d1.sums[j] + SUM_W'(prod[j] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      brow <= '0;
    end else begin
      if (load1) v1 <= in_valid;
      if (load2) v2 <= v1;
      // a load updates the row as it passes, so later multiplies see it
      if (load1 && in_valid && in_data.op == OP_LOAD && in_data.row == MY_ROW) begin
        brow <= in_data.elems;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      d1 <= in_data;
      for (int j = 0; j < DIM; j++) begin
        prod[j] <= mul[j];
      end
    end
    if (load2) begin
      d2 <= d2_next;
    end
  end

endmodule

### rtl/mrm_out.sv
module mrm_out (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mrm_pkg::chain_t              in_data,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [mrm_pkg::TDATA_W-1:0]  m_tdata
);
  import mrm_pkg::*;

  logic [DIM-1:0][ELEM_W-1:0] sat;
  logic [TDATA_W-1:0]         packed_data;

  // clamp each column sum to the signed 32-bit range
  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      if (&in_data.sums[j][SUM_W-1:ELEM_W-1] || ~|in_data.sums[j][SUM_W-1:ELEM_W-1]) begin
        sat[j] = in_data.sums[j][ELEM_W-1:0];
      end else if (in_data.sums[j][SUM_W-1]) begin
        sat[j] = SAT_NEG;
      end else begin
        sat[j] = SAT_POS;
      end
    end
  end

  assign packed_data = TDATA_W'({sat, in_data.row});
  assign in_ready    = !m_tvalid || m_tready;

  // drop load transactions here; only multiplies produce a result
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid && in_data.op == OP_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_tdata <= packed_data;
    end
  end

endmodule

### rtl/matrix4_row_multiply_top.sv
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: op; tdata: row_index, elem_0..elem_3
// m_*      out  m_tvalid/m_tready  tdata: out_row, prod_0..prod_3
//
// One transaction per cycle in steady state while m_tready is high. Each row of B lives in its own cell;
// a transaction passes through each cell's multiply and accumulate registers, then
// through the output register, before its result appears.
// Load transactions flow through the chain in order and leave no result.
// Reset clears B to zero. Stages hold independently: bubbles close up while
// m_tready is low; ready ripples combinationally from m_tready back to s_tready.
module matrix4_row_multiply_top #(
  parameter int FRAC_BITS = mrm_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [1:0] row_index, [33:2] elem_0, [65:34] elem_1, [97:66] elem_2,
  // [129:98] elem_3, rest zero
  input  logic [mrm_pkg::TDATA_W-1:0]  s_tdata,
  // [0] op
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [1:0] out_row, [33:2] prod_0, [65:34] prod_1, [97:66] prod_2,
  // [129:98] prod_3, rest zero
  output logic [mrm_pkg::TDATA_W-1:0]  m_tdata
);
  import mrm_pkg::*;

  chain_t link       [DIM+1];
  logic   link_valid [DIM+1];
  logic   link_ready [DIM+1];

  always_comb begin
    link[0].op  = s_tuser;
    link[0].row = s_tdata[ROW_W-1:0];
    for (int k = 0; k < DIM; k++) begin
      link[0].elems[k] = s_tdata[ROW_W + k * ELEM_W +: ELEM_W];
    end
    link[0].sums = '0;
  end

  assign link_valid[0] = s_tvalid;
  assign s_tready      = link_ready[0];

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    mrm_cell #(
      .CELL_IDX  (k),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[k]),
      .in_ready  (link_ready[k]),
      .in_data   (link[k]),
      .out_valid (link_valid[k+1]),
      .out_ready (link_ready[k+1]),
      .out_data  (link[k+1])
    );
  end

  mrm_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (link_valid[DIM]),
    .in_ready (link_ready[DIM]),
    .in_data  (link[DIM]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // a result only ever comes from a multiply leaving the last cell
  a_result_from_mul: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(link_valid[DIM] && link[DIM].op == OP_MUL))
    else $error("result raised without a multiply at the chain end");

  // with the output free, the whole chain moves and input is taken
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while the output side is free");

  // no result while the chain end delivered nothing
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid && !link_valid[DIM]) |=> !m_tvalid)
    else $error("result appeared from an empty chain");

endmodule
